[rtl/bmh_pkg.sv]
`default_nettype none

package bmh_pkg;

  // Default number of keys the heap can hold.
  localparam int CAPACITY_DEF = 1024;

  // Operation codes of a request.
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  // Status codes returned with every result.
  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // Request payload.
  typedef struct packed {
    op_t                operation;
    logic signed [31:0] key_value;
  } in_t;

  // Result payload.
  typedef struct packed {
    logic signed [31:0] min_value;
    logic               is_empty;
    logic [10:0]        entry_count;
    status_t            status;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    ins_start;  // claim the next free slot and latch the new key
    logic    del_start;  // drop one entry from the count
    logic    rd_up;      // read the parent of the hole
    logic    rd_last;    // read the entry just past the new count
    logic    rd_down;    // read both children of the hole
    logic    load_last;  // latch the last entry as the moving key, hole at the root
    logic    wr_key;     // write the moving key into the hole
    logic    up_move;    // move the parent down into the hole
    logic    dn_move;    // move the smaller child up into the hole
    logic    out_load;   // load the result register
    status_t status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_root;
    logic up_less;
    logic dn_stop;
  } sts_t;

endpackage

`default_nettype wire

[rtl/bmh_datapath.sv]
`default_nettype none

module bmh_datapath #(
  parameter int CAPACITY = bmh_pkg::CAPACITY_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire bmh_pkg::in_t  in_data,
  input  wire bmh_pkg::cmd_t cmd,
  output bmh_pkg::sts_t      sts,
  output bmh_pkg::out_t      out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;

  logic signed [31:0] mem_r [CAPACITY];

  logic [CW-1:0]      count_r, count_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic signed [31:0] root_r;
  logic signed [31:0] rd_a_r, rd_b_r;
  bmh_pkg::out_t      out_r;

  logic [AW-1:0]      parent;
  logic [IW-1:0]      left, right;
  logic               left_less, right_less;
  logic signed [31:0] best_val;
  logic [AW-1:0]      dn_idx;
  logic signed [31:0] dn_val;
  logic [AW-1:0]      rd_addr_a;
  logic               rd_en;
  logic               wr_en;
  logic signed [31:0] wr_data;

  // Tree neighbours of the hole.
  assign parent = (pos_r - AW'(1)) >> 1;
  assign left   = IW'({pos_r, 1'b1});
  assign right  = IW'({pos_r, 1'b0}) + IW'(2);

  // Pick the smaller child; the left one wins a tie, and the moving key wins over equals.
  assign left_less  = (left < IW'(count_r)) && (rd_a_r < key_r);
  assign best_val   = left_less ? rd_a_r : key_r;
  assign right_less = (right < IW'(count_r)) && (rd_b_r < best_val);
  assign dn_idx     = right_less ? right[AW-1:0] : left[AW-1:0];
  assign dn_val     = right_less ? rd_b_r : rd_a_r;

  // Status towards the controller.
  assign sts.full     = (count_r == CW'(CAPACITY));
  assign sts.empty    = (count_r == '0);
  assign sts.pos_root = (pos_r == '0);
  assign sts.up_less  = (key_r < rd_a_r);
  assign sts.dn_stop  = !left_less && !right_less;

  // Memory port selection.
  assign rd_en = cmd.rd_up || cmd.rd_last || cmd.rd_down;
  assign wr_en = cmd.wr_key || cmd.up_move || cmd.dn_move;

  always_comb begin
    priority if (cmd.rd_up) begin
      rd_addr_a = parent;
    end else if (cmd.rd_last) begin
      rd_addr_a = count_r[AW-1:0];
    end else begin
      rd_addr_a = left[AW-1:0];
    end
  end

  always_comb begin
    priority if (cmd.up_move) begin
      wr_data = rd_a_r;
    end else if (cmd.dn_move) begin
      wr_data = dn_val;
    end else begin
      wr_data = key_r;
    end
  end

  // Key store: one write port at the hole, two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[pos_r] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem_r[rd_addr_a];
      rd_b_r <= mem_r[right[AW-1:0]];
    end
  end

  // Copy of the root slot, kept for the result.
  always_ff @(posedge clk) begin
    if (wr_en && (pos_r == '0)) begin
      root_r <= wr_data;
    end
  end

  // Next count, hole position and moving key.
  always_comb begin
    count_nxt = count_r;
    pos_nxt   = pos_r;
    key_nxt   = key_r;
    if (cmd.ins_start) begin
      count_nxt = count_r + CW'(1);
      pos_nxt   = count_r[AW-1:0];
      key_nxt   = in_data.key_value;
    end
    if (cmd.del_start) begin
      count_nxt = count_r - CW'(1);
    end
    if (cmd.load_last) begin
      pos_nxt = '0;
      key_nxt = rd_a_r;
    end
    if (cmd.up_move) begin
      pos_nxt = parent;
    end
    if (cmd.dn_move) begin
      pos_nxt = dn_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    key_r <= key_nxt;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.min_value   <= (count_r == '0) ? 32'sd0 : root_r;
      out_r.is_empty    <= (count_r == '0);
      out_r.entry_count <= 11'(count_r);
      out_r.status      <= cmd.status;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

[rtl/bmh_ctrl.sv]
`default_nettype none

module bmh_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire bmh_pkg::op_t  in_op,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire bmh_pkg::sts_t sts,
  output bmh_pkg::cmd_t      cmd
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_UP_RD   = 8'b0000_0010,
    S_UP_CMP  = 8'b0000_0100,
    S_DN_LAST = 8'b0000_1000,
    S_DN_LOAD = 8'b0001_0000,
    S_DN_RD   = 8'b0010_0000,
    S_DN_CMP  = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  state_t           state_r, state_nxt;
  bmh_pkg::status_t status_r, status_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Sequencer for one request at a time.
  always_comb begin
    state_nxt     = state_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.status    = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          status_nxt = bmh_pkg::STAT_DONE;
          if (in_op == bmh_pkg::OP_INSERT) begin
            if (sts.full) begin
              status_nxt = bmh_pkg::STAT_FULL;
              state_nxt  = S_DONE;
            end else begin
              cmd.ins_start = 1'b1;
              state_nxt     = S_UP_RD;
            end
          end else begin
            if (sts.empty) begin
              status_nxt = bmh_pkg::STAT_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              cmd.del_start = 1'b1;
              state_nxt     = S_DN_LAST;
            end
          end
        end
      end
      S_UP_RD: begin
        if (sts.pos_root) begin
          cmd.wr_key = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          cmd.rd_up = 1'b1;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.up_less) begin
          cmd.up_move = 1'b1;
          state_nxt   = S_UP_RD;
        end else begin
          cmd.wr_key = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_DN_LAST: begin
        cmd.rd_last = 1'b1;
        state_nxt   = S_DN_LOAD;
      end
      S_DN_LOAD: begin
        cmd.load_last = 1'b1;
        state_nxt     = sts.empty ? S_DONE : S_DN_RD;
      end
      S_DN_RD: begin
        cmd.rd_down = 1'b1;
        state_nxt   = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (sts.dn_stop) begin
          cmd.wr_key = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          cmd.dn_move = 1'b1;
          state_nxt   = S_DN_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      status_r    <= bmh_pkg::STAT_DONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/binary_min_heap.sv]
// Priority queue of signed 32-bit keys held as a binary min-heap.
// Request channel (in_valid, in_ready, in_data): each request either
// inserts in_data.key_value or deletes the current minimum.
// Result channel (out_valid, out_ready, out_data): every request gives
// exactly one result with the minimum after the operation (zero when
// empty), the empty flag, the entry count and a status code: done,
// insert dropped because the heap is full, or delete on an empty heap.
// One request is worked on at a time: an insert lets the key climb level by
// level, a delete moves the last entry to the root and lets it sink level
// by level (no sinking when it empties the heap), and a rejected request
// goes straight to its result. Each level is a registered memory read
// followed by a compare and a single write.
// The result is presented in the same cycle in which the next request
// can be taken.
// A finished result sits in an output register, so the next request is
// accepted while the receiver stalls; a further result then waits in the
// sequencer until the register frees up.
// Reset (rst_n, synchronous) empties the heap at once; the key store is
// not cleared, as only slots below the count are ever used.
`default_nettype none

module binary_min_heap #(
  parameter int CAPACITY = bmh_pkg::CAPACITY_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bmh_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bmh_pkg::out_t      out_data
);

  bmh_pkg::cmd_t cmd;
  bmh_pkg::sts_t sts;

  // Sequencer.
  bmh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.operation),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Key store, hole tracking and result register.
  bmh_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

[rtl/bmh_checker.sv]
`default_nettype none

module bmh_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire bmh_pkg::out_t out_data
);

  // A stalled result stays and holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // An empty heap reports a zero minimum.
  a_empty_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |-> out_data.min_value == 32'sd0)
    else $error("empty heap with nonzero minimum");

  // A refused delete can only come from an empty heap.
  a_del_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == bmh_pkg::STAT_EMPTY) |-> out_data.is_empty)
    else $error("delete refused on a non-empty heap");

  // A dropped insert can only come from a full heap, so the heap must not be empty.
  a_ins_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == bmh_pkg::STAT_FULL) |-> !out_data.is_empty)
    else $error("insert dropped on an empty heap");

  // Only one request is worked on at a time, so ready drops after an accepted request.
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in progress");

endmodule

bind binary_min_heap bmh_checker u_bmh_checker (.*);

`default_nettype wire

[tb/tb.sv]
module tb;

  localparam int HEAP_CAP    = bmh_pkg::CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int DRAIN_WAIT  = 64;
  localparam int FULL_GOAL   = 20;

  // One line of the directed script: a request and, where it is obvious, its result.
  typedef struct packed {
    bmh_pkg::in_t  req;
    bit            typed;
    bmh_pkg::out_t want;
  } script_row_t;

  logic          clk;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_ready;
  bmh_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  bmh_pkg::out_t out_data;

  // Shadow copy of the heap, used to predict each result.
  logic signed [31:0] heap_keys [HEAP_CAP];
  int                 heap_size    = 0;
  int                 full_rejects = 0;

  bmh_pkg::out_t pending_results [$];
  script_row_t   script [$];
  int            mismatches = 0;
  int            cycles     = 0;
  int            idle_pct   = 0;
  int            stall_pct  = 0;

  binary_min_heap u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one request to the shadow heap and return the result it should give.
  function automatic bmh_pkg::out_t heap_step(input bmh_pkg::in_t req);
    bmh_pkg::out_t      res;
    int                 pos;
    int                 best;
    int                 lc;
    int                 rc;
    logic signed [31:0] tmp;
    bit                 settled;
    res        = '0;
    res.status = bmh_pkg::STAT_DONE;
    if (req.operation == bmh_pkg::OP_INSERT) begin
      if (heap_size >= HEAP_CAP) begin
        res.status = bmh_pkg::STAT_FULL;
        full_rejects++;
      end else begin
        // Append, then climb while strictly smaller than the parent.
        heap_keys[heap_size] = req.key_value;
        pos = heap_size;
        heap_size++;
        while (pos > 0 && heap_keys[pos] < heap_keys[(pos - 1) / 2]) begin
          tmp = heap_keys[pos];
          heap_keys[pos] = heap_keys[(pos - 1) / 2];
          heap_keys[(pos - 1) / 2] = tmp;
          pos = (pos - 1) / 2;
        end
      end
    end else if (heap_size == 0) begin
      res.status = bmh_pkg::STAT_EMPTY;
    end else begin
      // Last entry to the root, then sink towards the smaller child; left wins a tie.
      heap_size--;
      heap_keys[0] = heap_keys[heap_size];
      pos = 0;
      settled = 1'b0;
      while (!settled) begin
        lc = 2 * pos + 1;
        rc = 2 * pos + 2;
        best = pos;
        if (lc < heap_size && heap_keys[lc] < heap_keys[best]) best = lc;
        if (rc < heap_size && heap_keys[rc] < heap_keys[best]) best = rc;
        if (best == pos) begin
          settled = 1'b1;
        end else begin
          tmp = heap_keys[pos];
          heap_keys[pos] = heap_keys[best];
          heap_keys[best] = tmp;
          pos = best;
        end
      end
    end
    res.min_value   = (heap_size != 0) ? heap_keys[0] : 32'sd0;
    res.is_empty    = (heap_size == 0);
    res.entry_count = 11'(heap_size);
    return res;
  endfunction

  // Keys lean towards a narrow band, so that duplicates are common, and towards the extremes.
  function automatic logic signed [31:0] pick_key();
    logic signed [31:0] k;
    case ($urandom_range(7))
      0: k = 32'(int'($urandom_range(15)) - 8);
      1: begin
        case ($urandom_range(3))
          0: k = 32'h8000_0000;
          1: k = 32'h7fff_ffff;
          2: k = 32'h0000_0000;
          default: k = 32'hffff_ffff;
        endcase
      end
      default: k = $urandom();
    endcase
    return k;
  endfunction

  task automatic add_row(input bmh_pkg::op_t op, input logic [31:0] key, input bit typed,
                         input logic [31:0] mn, input bit emp, input logic [10:0] cnt,
                         input bmh_pkg::status_t st);
    script_row_t row;
    row.req.operation   = op;
    row.req.key_value   = key;
    row.typed           = typed;
    row.want.min_value  = mn;
    row.want.is_empty   = emp;
    row.want.entry_count = cnt;
    row.want.status     = st;
    script = {script, row};
  endtask

  // Present one request, hold it until accepted, and record what it should return.
  task automatic send_request(input bmh_pkg::in_t req, input bit typed,
                              input bmh_pkg::out_t want);
    int            gap;
    bmh_pkg::out_t predicted;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    predicted = heap_step(req);
    pending_results = {pending_results, (typed ? want : predicted)};
  endtask

  task automatic send_random(input int insert_weight);
    bmh_pkg::in_t req;
    req.operation = ($urandom_range(31) < insert_weight) ? bmh_pkg::OP_INSERT
                                                         : bmh_pkg::OP_DELETE;
    req.key_value = pick_key();
    send_request(req, 1'b0, '0);
  endtask

  task automatic report_field(input string field, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %h, got %h", field, exp_v, act_v);
  endtask

  // Receiver: ready held high, or dropped at random in the stalling phases.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare every accepted result with the oldest one outstanding.
  always @(posedge clk) begin
    bmh_pkg::out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.min_value !== exp_r.min_value)
          report_field("min_value", exp_r.min_value, out_data.min_value);
        if (out_data.is_empty !== exp_r.is_empty)
          report_field("is_empty", 32'(exp_r.is_empty), 32'(out_data.is_empty));
        if (out_data.entry_count !== exp_r.entry_count)
          report_field("entry_count", 32'(exp_r.entry_count), 32'(out_data.entry_count));
        if (out_data.status !== exp_r.status)
          report_field("status", 32'(exp_r.status), 32'(out_data.status));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    // Directed script: empty-heap deletes, extreme keys, equal keys and a full drain.
    add_row(bmh_pkg::OP_DELETE, 32'h0000_0000, 1'b1, 32'h0, 1'b1, 11'd0, bmh_pkg::STAT_EMPTY);
    add_row(bmh_pkg::OP_INSERT, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff, 1'b0, 11'd1,
            bmh_pkg::STAT_DONE);
    add_row(bmh_pkg::OP_INSERT, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0, 11'd2,
            bmh_pkg::STAT_DONE);
    add_row(bmh_pkg::OP_INSERT, 32'h0000_0000, 1'b1, 32'h8000_0000, 1'b0, 11'd3,
            bmh_pkg::STAT_DONE);
    add_row(bmh_pkg::OP_INSERT, 32'hffff_ffff, 1'b1, 32'h8000_0000, 1'b0, 11'd4,
            bmh_pkg::STAT_DONE);
    add_row(bmh_pkg::OP_INSERT, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0, 11'd5,
            bmh_pkg::STAT_DONE);
    add_row(bmh_pkg::OP_INSERT, 32'h0000_0005, 1'b0, '0, 1'b0, '0, bmh_pkg::STAT_DONE);
    add_row(bmh_pkg::OP_INSERT, 32'h0000_0005, 1'b0, '0, 1'b0, '0, bmh_pkg::STAT_DONE);
    add_row(bmh_pkg::OP_INSERT, 32'h0000_0005, 1'b0, '0, 1'b0, '0, bmh_pkg::STAT_DONE);
    // Deletes carry junk in the key, which must be ignored.
    add_row(bmh_pkg::OP_DELETE, 32'hffff_ffff, 1'b0, '0, 1'b0, '0, bmh_pkg::STAT_DONE);
    add_row(bmh_pkg::OP_DELETE, 32'h5555_aaaa, 1'b0, '0, 1'b0, '0, bmh_pkg::STAT_DONE);
    add_row(bmh_pkg::OP_DELETE, 32'h0000_0000, 1'b0, '0, 1'b0, '0, bmh_pkg::STAT_DONE);
    add_row(bmh_pkg::OP_DELETE, 32'haaaa_5555, 1'b0, '0, 1'b0, '0, bmh_pkg::STAT_DONE);
    add_row(bmh_pkg::OP_DELETE, 32'h0000_0000, 1'b0, '0, 1'b0, '0, bmh_pkg::STAT_DONE);
    add_row(bmh_pkg::OP_DELETE, 32'h0000_0000, 1'b0, '0, 1'b0, '0, bmh_pkg::STAT_DONE);
    add_row(bmh_pkg::OP_DELETE, 32'h0000_0000, 1'b1, 32'h7fff_ffff, 1'b0, 11'd1,
            bmh_pkg::STAT_DONE);
    add_row(bmh_pkg::OP_DELETE, 32'h0000_0000, 1'b1, 32'h0, 1'b1, 11'd0, bmh_pkg::STAT_DONE);
    add_row(bmh_pkg::OP_DELETE, 32'hffff_ffff, 1'b1, 32'h0, 1'b1, 11'd0, bmh_pkg::STAT_EMPTY);
    add_row(bmh_pkg::OP_INSERT, 32'hffff_ffff, 1'b1, 32'hffff_ffff, 1'b0, 11'd1,
            bmh_pkg::STAT_DONE);
    add_row(bmh_pkg::OP_DELETE, 32'h0000_0000, 1'b1, 32'h0, 1'b1, 11'd0, bmh_pkg::STAT_DONE);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) send_request(script[i].req, script[i].typed, script[i].want);

    // Mixed traffic around an almost empty heap, no idling.
    repeat (50) send_random(16);

    // Sender idles while the heap grows.
    idle_pct = 51;
    repeat (250) send_random(28);

    // Receiver stalls; keep inserting until the full heap has rejected plenty.
    idle_pct  = 0;
    stall_pct = 51;
    while (full_rejects < FULL_GOAL) send_random(31);

    // Both sides idle while the heap shrinks.
    idle_pct  = 34;
    stall_pct = 34;
    repeat (60) send_random(8);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

[sim.f]
rtl/bmh_pkg.sv
rtl/bmh_datapath.sv
rtl/bmh_ctrl.sv
rtl/binary_min_heap.sv
rtl/bmh_checker.sv
tb/tb.sv
